// File: rtl/gtbi_pkg.sv
// Shared constants, register codes and word types of the bilinear table lookup unit.
package gtbi_pkg;

   localparam int TEMP_POINTS_DEF = 64;
   localparam int PRES_POINTS_DEF = 64;
   localparam int TABLE_COUNT_DEF = 8;
   localparam int FRAC_BITS_DEF   = 16;

   localparam int TEMP_W      = 17;
   localparam int PRES_W      = 16;
   localparam int STEP_W      = 16;
   localparam int USED_W      = 7;
   localparam int SEL_W       = 3;
   localparam int IDX_W       = 6;
   localparam int VALUE_W     = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int QUOT_INT_W  = USED_W;
   localparam int QUEUE_DEPTH = 4;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_TEMP_ORIGIN = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEMP_STEP   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRES_ORIGIN = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRES_STEP   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEMP_USED   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRES_USED   = 3'd5;

   localparam logic [TEMP_W-1:0] TEMP_ORIGIN_RST = 17'd71206;
   localparam logic [STEP_W-1:0] TEMP_STEP_RST   = 16'd256;
   localparam logic [PRES_W-1:0] PRES_ORIGIN_RST = 16'd24800;
   localparam logic [STEP_W-1:0] PRES_STEP_RST   = 16'd160;
   localparam logic [USED_W-1:0] TEMP_USED_RST   = 7'd64;
   localparam logic [USED_W-1:0] PRES_USED_RST   = 7'd64;

   typedef struct packed {
      logic [TEMP_W-1:0] temp_origin;
      logic [STEP_W-1:0] temp_step;
      logic [PRES_W-1:0] pres_origin;
      logic [STEP_W-1:0] pres_step;
      logic [USED_W-1:0] temp_used;
      logic [USED_W-1:0] pres_used;
   } cfg_type;

   typedef struct packed {
      logic                      lookup;
      logic [SEL_W-1:0]          sel;
      logic                      oor;
      logic [TEMP_W-1:0]         temp_off;
      logic [PRES_W-1:0]         pres_off;
      logic [IDX_W-1:0]          row;
      logic [IDX_W-1:0]          col;
      logic signed [VALUE_W-1:0] value;
   } item_type;

endpackage

// File: rtl/gtbi_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gtbi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/gtbi_front.sv
// Front end: accepts request words, checks grid bounds and drops bad loads.
module gtbi_front #(
   parameter int TEMP_POINTS = gtbi_pkg::TEMP_POINTS_DEF,
   parameter int PRES_POINTS = gtbi_pkg::PRES_POINTS_DEF,
   parameter int TABLE_COUNT = gtbi_pkg::TABLE_COUNT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  gtbi_pkg::cfg_type                 cfg,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_op,
   input  logic [gtbi_pkg::SEL_W-1:0]        req_table_sel,
   input  logic [gtbi_pkg::TEMP_W-1:0]       req_temperature,
   input  logic [gtbi_pkg::PRES_W-1:0]       req_pressure,
   input  logic [gtbi_pkg::IDX_W-1:0]        req_load_row,
   input  logic [gtbi_pkg::IDX_W-1:0]        req_load_col,
   input  logic signed [gtbi_pkg::VALUE_W-1:0] req_load_value,
   output logic                              item_valid,
   input  logic                              item_ready,
   output gtbi_pkg::item_type                item
);

   localparam int SPAN_W = gtbi_pkg::USED_W + gtbi_pkg::STEP_W;

   logic                   valid_ff, valid_in;
   gtbi_pkg::item_type     item_ff, item_in;
   logic                   accept, keep, sel_bad, load_ok, temp_bad, pres_bad;
   logic [gtbi_pkg::USED_W-1:0] temp_n, pres_n;
   logic [gtbi_pkg::TEMP_W-1:0] temp_off;
   logic [gtbi_pkg::PRES_W-1:0] pres_off;
   logic [SPAN_W-1:0]      temp_span, pres_span;

   assign req_ready = !valid_ff || item_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      temp_n = (11'(cfg.temp_used) > 11'(TEMP_POINTS)) ?
               gtbi_pkg::USED_W'(TEMP_POINTS) : cfg.temp_used;
      pres_n = (11'(cfg.pres_used) > 11'(PRES_POINTS)) ?
               gtbi_pkg::USED_W'(PRES_POINTS) : cfg.pres_used;
      temp_off  = req_temperature - cfg.temp_origin;
      pres_off  = req_pressure - cfg.pres_origin;
      temp_span = SPAN_W'(temp_n - 7'd1) * SPAN_W'(cfg.temp_step);
      pres_span = SPAN_W'(pres_n - 7'd1) * SPAN_W'(cfg.pres_step);
      temp_bad  = (temp_n < 7'd2) || (cfg.temp_step == '0) ||
                  (req_temperature < cfg.temp_origin) || (SPAN_W'(temp_off) >= temp_span);
      pres_bad  = (pres_n < 7'd2) || (cfg.pres_step == '0) ||
                  (req_pressure < cfg.pres_origin) || (SPAN_W'(pres_off) >= pres_span);
      sel_bad   = 5'(req_table_sel) >= 5'(TABLE_COUNT);
      load_ok   = !sel_bad && (11'(req_load_row) < 11'(TEMP_POINTS)) &&
                  (11'(req_load_col) < 11'(PRES_POINTS));
      keep      = (req_op == gtbi_pkg::OP_LOOKUP) || load_ok;

      item_in.lookup   = (req_op == gtbi_pkg::OP_LOOKUP);
      item_in.sel      = req_table_sel;
      item_in.oor      = sel_bad || temp_bad || pres_bad;
      item_in.temp_off = temp_off;
      item_in.pres_off = pres_off;
      item_in.row      = req_load_row;
      item_in.col      = req_load_col;
      item_in.value    = req_load_value;

      valid_in = accept ? keep : (valid_ff && !item_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// File: rtl/gtbi_queue.sv
// Short word queue that decouples the front end from the back end.
module gtbi_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  gtbi_pkg::item_type push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output gtbi_pkg::item_type pop_item
);

   localparam int PW = $clog2(gtbi_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(gtbi_pkg::QUEUE_DEPTH + 1);

   gtbi_pkg::item_type slot_ff [gtbi_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          push, pop;

   assign push_ready = (count_ff != CW'(gtbi_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/gtbi_div.sv
// Pipelined restoring divider giving cell index and fraction on both axes.
module gtbi_div #(
   parameter int FRAC_BITS = gtbi_pkg::FRAC_BITS_DEF,
   localparam int K = gtbi_pkg::QUOT_INT_W + FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  gtbi_pkg::cfg_type  cfg,
   input  logic               in_valid,
   input  gtbi_pkg::item_type in_item,
   output logic               out_valid,
   output gtbi_pkg::item_type out_item,
   output logic [K-1:0]       out_temp_quot,
   output logic [K-1:0]       out_pres_quot
);

   localparam int SW = gtbi_pkg::STEP_W;

   logic [K:0]         valid_ff, valid_in;
   gtbi_pkg::item_type item_ff [K+1];
   logic [SW-1:0]      trem_ff [K+1];
   logic [SW-1:0]      trem_in [K+1];
   logic [SW-1:0]      prem_ff [K+1];
   logic [SW-1:0]      prem_in [K+1];
   logic [K-1:0]       tq_ff [K+1];
   logic [K-1:0]       tq_in [K+1];
   logic [K-1:0]       pq_ff [K+1];
   logic [K-1:0]       pq_in [K+1];
   logic [SW:0]        t_trial [K+1];
   logic [SW:0]        p_trial [K+1];

   always_comb begin
      valid_in   = {valid_ff[K-1:0], in_valid};
      t_trial[0] = '0;
      p_trial[0] = '0;
      trem_in[0] = SW'(in_item.temp_off >> gtbi_pkg::QUOT_INT_W);
      prem_in[0] = SW'(in_item.pres_off >> gtbi_pkg::QUOT_INT_W);
      tq_in[0]   = {in_item.temp_off[gtbi_pkg::QUOT_INT_W-1:0], {FRAC_BITS{1'b0}}};
      pq_in[0]   = {in_item.pres_off[gtbi_pkg::QUOT_INT_W-1:0], {FRAC_BITS{1'b0}}};
      for (int k = 1; k <= K; k++) begin
         t_trial[k] = {trem_ff[k-1], tq_ff[k-1][K-1]};
         p_trial[k] = {prem_ff[k-1], pq_ff[k-1][K-1]};
         if (t_trial[k] >= {1'b0, cfg.temp_step}) begin
            trem_in[k] = SW'(t_trial[k] - {1'b0, cfg.temp_step});
            tq_in[k]   = {tq_ff[k-1][K-2:0], 1'b1};
         end else begin
            trem_in[k] = t_trial[k][SW-1:0];
            tq_in[k]   = {tq_ff[k-1][K-2:0], 1'b0};
         end
         if (p_trial[k] >= {1'b0, cfg.pres_step}) begin
            prem_in[k] = SW'(p_trial[k] - {1'b0, cfg.pres_step});
            pq_in[k]   = {pq_ff[k-1][K-2:0], 1'b1};
         end else begin
            prem_in[k] = p_trial[k][SW-1:0];
            pq_in[k]   = {pq_ff[k-1][K-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         item_ff[0] <= in_item;
         for (int k = 0; k <= K; k++) begin
            trem_ff[k] <= trem_in[k];
            prem_ff[k] <= prem_in[k];
            tq_ff[k]   <= tq_in[k];
            pq_ff[k]   <= pq_in[k];
         end
         for (int k = 1; k <= K; k++) begin
            item_ff[k] <= item_ff[k-1];
         end
      end
   end

   assign out_valid     = valid_ff[K];
   assign out_item      = item_ff[K];
   assign out_temp_quot = tq_ff[K];
   assign out_pres_quot = pq_ff[K];

endmodule

// File: rtl/gtbi_back.sv
// Back end: divider, parity-banked table store, two-pass blend and result register.
module gtbi_back #(
   parameter int TEMP_POINTS = gtbi_pkg::TEMP_POINTS_DEF,
   parameter int PRES_POINTS = gtbi_pkg::PRES_POINTS_DEF,
   parameter int TABLE_COUNT = gtbi_pkg::TABLE_COUNT_DEF,
   parameter int FRAC_BITS   = gtbi_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  gtbi_pkg::cfg_type                    cfg,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  gtbi_pkg::item_type                   in_item,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [gtbi_pkg::VALUE_W-1:0]  rsp_result_value,
   output logic                                 rsp_out_of_range
);

   localparam int K          = gtbi_pkg::QUOT_INT_W + FRAC_BITS;
   localparam int VW         = gtbi_pkg::VALUE_W;
   localparam int ROW_W      = $clog2(TEMP_POINTS);
   localparam int COL_W      = $clog2(PRES_POINTS);
   localparam int HALF_T     = (TEMP_POINTS + 1) / 2;
   localparam int HALF_P     = (PRES_POINTS + 1) / 2;
   localparam int BANK_DEPTH = TABLE_COUNT * HALF_T * HALF_P;
   localparam int BA_W       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int PW         = VW + FRAC_BITS + 2;
   localparam int SUM_W      = PW + 1;
   localparam logic signed [SUM_W-1:0] HALF =
      {{(SUM_W - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
   localparam logic [FRAC_BITS:0] SCALE = {1'b1, {FRAC_BITS{1'b0}}};

   logic               advance;
   logic               d_valid;
   gtbi_pkg::item_type d_item;
   logic [K-1:0]       d_tq, d_pq;
   logic [ROW_W-1:0]   it, it1, load_row;
   logic [COL_W-1:0]   jp, jp1, load_col;
   logic [BA_W-1:0]    bank_addr [4];
   logic               bank_we [4];
   logic [VW-1:0]      bank_rdata [4];

   logic                   m_valid_ff, m_oor_ff, m_it0_ff, m_jp0_ff;
   logic [FRAC_BITS-1:0]   m_ft_ff, m_fp_ff;
   logic signed [VW-1:0]   v00, v10, v01, v11;
   logic signed [FRAC_BITS+1:0] wt0, wt1, wp0, wp1;

   logic                   b1_valid_ff, b1_oor_ff;
   logic [FRAC_BITS-1:0]   b1_fp_ff;
   logic signed [PW-1:0]   p0_ff, p1_ff, p2_ff, p3_ff;
   logic signed [PW-1:0]   p0_in, p1_in, p2_in, p3_in;

   logic                   b2_valid_ff, b2_oor_ff;
   logic [FRAC_BITS-1:0]   b2_fp_ff;
   logic signed [VW-1:0]   a0_ff, a1_ff, a0_in, a1_in;
   logic signed [SUM_W-1:0] s0, s1, s2;

   logic                   b3_valid_ff, b3_oor_ff;
   logic signed [PW-1:0]   q0_ff, q1_ff, q0_in, q1_in;

   logic                   out_valid_ff, out_valid_in, out_oor_ff;
   logic signed [VW-1:0]   out_value_ff, out_value_in;

   function automatic logic [BA_W-1:0] bank_index(
      input logic [gtbi_pkg::SEL_W-1:0] sel,
      input logic [ROW_W-1:0]           r,
      input logic [COL_W-1:0]           c
   );
      logic [31:0] lin;
      lin = (32'(sel) * 32'(HALF_T) + 32'(r >> 1)) * 32'(HALF_P) + 32'(c >> 1);
      return lin[BA_W-1:0];
   endfunction

   assign advance  = !out_valid_ff || rsp_ready;
   assign in_ready = advance;

   gtbi_div #(
      .FRAC_BITS(FRAC_BITS)
   ) u_div (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .cfg          (cfg),
      .in_valid     (in_valid),
      .in_item      (in_item),
      .out_valid    (d_valid),
      .out_item     (d_item),
      .out_temp_quot(d_tq),
      .out_pres_quot(d_pq)
   );

   always_comb begin
      it       = ROW_W'(d_tq[K-1:FRAC_BITS]);
      jp       = COL_W'(d_pq[K-1:FRAC_BITS]);
      it1      = it + 1'b1;
      jp1      = jp + 1'b1;
      load_row = ROW_W'(d_item.row);
      load_col = COL_W'(d_item.col);
      for (int b = 0; b < 4; b++) begin
         if (d_item.lookup) begin
            bank_addr[b] = bank_index(d_item.sel,
                                      (it[0] == b[1]) ? it : it1,
                                      (jp[0] == b[0]) ? jp : jp1);
            bank_we[b]   = 1'b0;
         end else begin
            bank_addr[b] = bank_index(d_item.sel, load_row, load_col);
            bank_we[b]   = d_valid && advance &&
                           (load_row[0] == b[1]) && (load_col[0] == b[0]);
         end
      end
   end

   for (genvar g = 0; g < 4; g++) begin : g_bank
      gtbi_ram #(
         .WIDTH(VW),
         .DEPTH(BANK_DEPTH)
      ) u_bank (
         .clock  (clock),
         .wr_en  (bank_we[g]),
         .wr_addr(bank_addr[g]),
         .wr_data(d_item.value),
         .rd_en  (advance),
         .rd_addr(bank_addr[g]),
         .rd_data(bank_rdata[g])
      );
   end

   always_comb begin
      v00 = bank_rdata[{m_it0_ff, m_jp0_ff}];
      v10 = bank_rdata[{!m_it0_ff, m_jp0_ff}];
      v01 = bank_rdata[{m_it0_ff, !m_jp0_ff}];
      v11 = bank_rdata[{!m_it0_ff, !m_jp0_ff}];
      wt1 = signed'({2'b00, m_ft_ff});
      wt0 = signed'({1'b0, SCALE - {1'b0, m_ft_ff}});
      p0_in = PW'(v00) * PW'(wt0);
      p1_in = PW'(v10) * PW'(wt1);
      p2_in = PW'(v01) * PW'(wt0);
      p3_in = PW'(v11) * PW'(wt1);

      s0    = SUM_W'(p0_ff) + SUM_W'(p1_ff) + HALF;
      s1    = SUM_W'(p2_ff) + SUM_W'(p3_ff) + HALF;
      a0_in = s0[FRAC_BITS +: VW];
      a1_in = s1[FRAC_BITS +: VW];

      wp1   = signed'({2'b00, b2_fp_ff});
      wp0   = signed'({1'b0, SCALE - {1'b0, b2_fp_ff}});
      q0_in = PW'(a0_ff) * PW'(wp0);
      q1_in = PW'(a1_ff) * PW'(wp1);

      s2           = SUM_W'(q0_ff) + SUM_W'(q1_ff) + HALF;
      out_value_in = b3_oor_ff ? '0 : s2[FRAC_BITS +: VW];
      out_valid_in = advance ? b3_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff   <= 1'b0;
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         b3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (advance) begin
            m_valid_ff  <= d_valid && d_item.lookup;
            b1_valid_ff <= m_valid_ff;
            b2_valid_ff <= b1_valid_ff;
            b3_valid_ff <= b2_valid_ff;
         end
      end
      if (advance) begin
         m_oor_ff     <= d_item.oor;
         m_it0_ff     <= it[0];
         m_jp0_ff     <= jp[0];
         m_ft_ff      <= d_tq[FRAC_BITS-1:0];
         m_fp_ff      <= d_pq[FRAC_BITS-1:0];
         b1_oor_ff    <= m_oor_ff;
         b1_fp_ff     <= m_fp_ff;
         p0_ff        <= p0_in;
         p1_ff        <= p1_in;
         p2_ff        <= p2_in;
         p3_ff        <= p3_in;
         b2_oor_ff    <= b1_oor_ff;
         b2_fp_ff     <= b1_fp_ff;
         a0_ff        <= a0_in;
         a1_ff        <= a1_in;
         b3_oor_ff    <= b2_oor_ff;
         q0_ff        <= q0_in;
         q1_ff        <= q1_in;
         out_oor_ff   <= b3_oor_ff;
         out_value_ff <= out_value_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_value = out_value_ff;
   assign rsp_out_of_range = out_oor_ff;

endmodule

// File: rtl/grid_table_bilinear_interp_unit.sv
// Top level of the bilinear grid table lookup unit: registers, front end, queue, back end.
// A lookup word passes the front register, the queue, the one-bit-per-stage divider, the
// memory read and two blend passes before its result is shown.
// Throughput: one word per cycle while results are taken; four parity-banked memories
// give the four corners. A load word writes its entry as it leaves the divider, in order.
// Reset clears all valid flags and loads the default grid registers; table contents
// stay undefined until written, and the block accepts words right after reset.
module grid_table_bilinear_interp_unit #(
   parameter int TEMP_POINTS = gtbi_pkg::TEMP_POINTS_DEF,
   parameter int PRES_POINTS = gtbi_pkg::PRES_POINTS_DEF,
   parameter int TABLE_COUNT = gtbi_pkg::TABLE_COUNT_DEF,
   parameter int FRAC_BITS   = gtbi_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_op,
   input  logic [gtbi_pkg::SEL_W-1:0]           req_table_sel,
   input  logic [gtbi_pkg::TEMP_W-1:0]          req_temperature,
   input  logic [gtbi_pkg::PRES_W-1:0]          req_pressure,
   input  logic [gtbi_pkg::IDX_W-1:0]           req_load_row,
   input  logic [gtbi_pkg::IDX_W-1:0]           req_load_col,
   input  logic signed [gtbi_pkg::VALUE_W-1:0]  req_load_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [gtbi_pkg::VALUE_W-1:0]  rsp_result_value,
   output logic                                 rsp_out_of_range,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gtbi_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [gtbi_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   gtbi_pkg::cfg_type  cfg_ff, cfg_in;
   logic               f_valid, f_ready, q_valid, q_ready;
   gtbi_pkg::item_type f_item, q_item;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            gtbi_pkg::CSR_TEMP_ORIGIN: cfg_in.temp_origin = csr_wdata[gtbi_pkg::TEMP_W-1:0];
            gtbi_pkg::CSR_TEMP_STEP:   cfg_in.temp_step   = csr_wdata[gtbi_pkg::STEP_W-1:0];
            gtbi_pkg::CSR_PRES_ORIGIN: cfg_in.pres_origin = csr_wdata[gtbi_pkg::PRES_W-1:0];
            gtbi_pkg::CSR_PRES_STEP:   cfg_in.pres_step   = csr_wdata[gtbi_pkg::STEP_W-1:0];
            gtbi_pkg::CSR_TEMP_USED:   cfg_in.temp_used   = csr_wdata[gtbi_pkg::USED_W-1:0];
            gtbi_pkg::CSR_PRES_USED:   cfg_in.pres_used   = csr_wdata[gtbi_pkg::USED_W-1:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.temp_origin <= gtbi_pkg::TEMP_ORIGIN_RST;
         cfg_ff.temp_step   <= gtbi_pkg::TEMP_STEP_RST;
         cfg_ff.pres_origin <= gtbi_pkg::PRES_ORIGIN_RST;
         cfg_ff.pres_step   <= gtbi_pkg::PRES_STEP_RST;
         cfg_ff.temp_used   <= gtbi_pkg::TEMP_USED_RST;
         cfg_ff.pres_used   <= gtbi_pkg::PRES_USED_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gtbi_front #(
      .TEMP_POINTS(TEMP_POINTS),
      .PRES_POINTS(PRES_POINTS),
      .TABLE_COUNT(TABLE_COUNT)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_table_sel  (req_table_sel),
      .req_temperature(req_temperature),
      .req_pressure   (req_pressure),
      .req_load_row   (req_load_row),
      .req_load_col   (req_load_col),
      .req_load_value (req_load_value),
      .item_valid     (f_valid),
      .item_ready     (f_ready),
      .item           (f_item)
   );

   gtbi_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(f_valid),
      .push_ready(f_ready),
      .push_item (f_item),
      .pop_valid (q_valid),
      .pop_ready (q_ready),
      .pop_item  (q_item)
   );

   gtbi_back #(
      .TEMP_POINTS(TEMP_POINTS),
      .PRES_POINTS(PRES_POINTS),
      .TABLE_COUNT(TABLE_COUNT),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .in_valid        (q_valid),
      .in_ready        (q_ready),
      .in_item         (q_item),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_value(rsp_result_value),
      .rsp_out_of_range(rsp_out_of_range)
   );

endmodule

// File: rtl/gtbi_checker.sv
// Port-level checks of the bilinear grid table lookup unit and their binding.
module gtbi_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [gtbi_pkg::VALUE_W-1:0] rsp_result_value,
   input logic                                rsp_out_of_range,
   input logic                                csr_valid,
   input logic                                csr_ready
);

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_result_value == '0)
      else $error("Out-of-range result word carries a nonzero value.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value) &&
      $stable(rsp_out_of_range))
      else $error("Stalled result word changed or dropped.");

   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("Result word shown right after reset.");

   a_csr_taken: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("Register write was not taken at once.");

endmodule

bind grid_table_bilinear_interp_unit gtbi_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_result_value(rsp_result_value),
   .rsp_out_of_range(rsp_out_of_range),
   .csr_valid       (csr_valid),
   .csr_ready       (csr_ready)
);

// File: sim/grid_table_bilinear_interp_unit_tb.sv
// Self-checking testbench for the bilinear grid table lookup unit.
`timescale 1ns / 100ps

module grid_table_bilinear_interp_unit_tb;

   localparam int TPTS = gtbi_pkg::TEMP_POINTS_DEF;
   localparam int PPTS = gtbi_pkg::PRES_POINTS_DEF;
   localparam int TCNT = gtbi_pkg::TABLE_COUNT_DEF;
   localparam int FBITS = gtbi_pkg::FRAC_BITS_DEF;
   localparam int VW = gtbi_pkg::VALUE_W;
   localparam int CIW = gtbi_pkg::CSR_INDEX_W;
   localparam int CDW = gtbi_pkg::CSR_DATA_W;
   localparam int SETTLE_CYCLES = gtbi_pkg::FRAC_BITS_DEF + 30;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASES = 10;
   localparam int ITEMS_PER_PHASE = 180;
   localparam logic [CIW-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CIW-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct {
      logic signed [VW-1:0] value;
      logic                 oor;
   } lookup_result_type;

   class interp_scoreboard;
      logic signed [VW-1:0] table_words [TCNT*TPTS*PPTS];
      bit                   written [TCNT*TPTS*PPTS];
      longint               temp_origin, temp_step, pres_origin, pres_step;
      longint               temp_used, pres_used;
      lookup_result_type    pending [$];
      int                   mismatches;

      function new();
         temp_origin = gtbi_pkg::TEMP_ORIGIN_RST;
         temp_step   = gtbi_pkg::TEMP_STEP_RST;
         pres_origin = gtbi_pkg::PRES_ORIGIN_RST;
         pres_step   = gtbi_pkg::PRES_STEP_RST;
         temp_used   = gtbi_pkg::TEMP_USED_RST;
         pres_used   = gtbi_pkg::PRES_USED_RST;
         mismatches  = 0;
      endfunction

      function int addr_of(int sel, int row, int col);
         return (sel * TPTS + row) * PPTS + col;
      endfunction

      function void set_reg(logic [CIW-1:0] idx, logic [CDW-1:0] data);
         case (idx)
            gtbi_pkg::CSR_TEMP_ORIGIN: temp_origin = data[gtbi_pkg::TEMP_W-1:0];
            gtbi_pkg::CSR_TEMP_STEP:   temp_step   = data[gtbi_pkg::STEP_W-1:0];
            gtbi_pkg::CSR_PRES_ORIGIN: pres_origin = data[gtbi_pkg::PRES_W-1:0];
            gtbi_pkg::CSR_PRES_STEP:   pres_step   = data[gtbi_pkg::STEP_W-1:0];
            gtbi_pkg::CSR_TEMP_USED:   temp_used   = data[gtbi_pkg::USED_W-1:0];
            gtbi_pkg::CSR_PRES_USED:   pres_used   = data[gtbi_pkg::USED_W-1:0];
            default: ;
         endcase
      endfunction

      function bit find_cell(longint pos, longint origin, longint step, longint used,
                             longint limit, output int idx, output longint frac);
         longint n, off;
         n = (used > limit) ? limit : used;
         idx = 0;
         frac = 0;
         if (n < 2 || step == 0 || pos < origin) return 0;
         off = pos - origin;
         if (off / step > n - 2) return 0;
         idx = int'(off / step);
         frac = ((off % step) << FBITS) / step;
         return 1;
      endfunction

      function longint round_frac(longint x);
         return (x + (longint'(1) << (FBITS - 1))) >>> FBITS;
      endfunction

      function longint word_at(int sel, int row, int col);
         return longint'(table_words[addr_of(sel, row, col)]);
      endfunction

      function void note_word(logic op, int sel, longint temp, longint pres,
                              int row, int col, logic signed [VW-1:0] val);
         int it, jp;
         longint ft, fp, a0, a1, blend, full;
         lookup_result_type res;
         full = longint'(1) << FBITS;
         if (op == gtbi_pkg::OP_LOAD) begin
            if (sel < TCNT && row < TPTS && col < PPTS) begin
               table_words[addr_of(sel, row, col)] = val;
               written[addr_of(sel, row, col)] = 1;
            end
            return;
         end
         if (sel >= TCNT ||
             !find_cell(temp, temp_origin, temp_step, temp_used, TPTS, it, ft) ||
             !find_cell(pres, pres_origin, pres_step, pres_used, PPTS, jp, fp)) begin
            res.value = '0;
            res.oor = 1'b1;
         end else begin
            a0 = round_frac(word_at(sel, it, jp) * (full - ft) + word_at(sel, it + 1, jp) * ft);
            a1 = round_frac(word_at(sel, it, jp + 1) * (full - ft) +
                            word_at(sel, it + 1, jp + 1) * ft);
            blend = round_frac(a0 * (full - fp) + a1 * fp);
            res.value = blend[VW-1:0];
            res.oor = 1'b0;
         end
         pending.push_back(res);
      endfunction

      function void check_result(logic signed [VW-1:0] value, logic oor);
         lookup_result_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result value=%0d oor=%b", value, oor);
            return;
         end
         want = pending.pop_front();
         if (value !== want.value || oor !== want.oor) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: expected value=%0d oor=%b, got value=%0d oor=%b",
                        want.value, want.oor, value, oor);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_op = gtbi_pkg::OP_LOAD;
   logic [gtbi_pkg::SEL_W-1:0] req_table_sel = '0;
   logic [gtbi_pkg::TEMP_W-1:0] req_temperature = '0;
   logic [gtbi_pkg::PRES_W-1:0] req_pressure = '0;
   logic [gtbi_pkg::IDX_W-1:0] req_load_row = '0;
   logic [gtbi_pkg::IDX_W-1:0] req_load_col = '0;
   logic signed [VW-1:0] req_load_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [VW-1:0] rsp_result_value;
   logic rsp_out_of_range;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CIW-1:0] csr_index = '0;
   logic [CDW-1:0] csr_wdata = '0;

   interp_scoreboard sb = new();
   bit req_idle_on = 1;
   bit rsp_idle_on = 1;
   bit hold_request = 0;
   int sent_words = 0;

   always #5 clock = ~clock;

   grid_table_bilinear_interp_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_table_sel(req_table_sel), .req_temperature(req_temperature),
      .req_pressure(req_pressure), .req_load_row(req_load_row),
      .req_load_col(req_load_col), .req_load_value(req_load_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_value(rsp_result_value), .rsp_out_of_range(rsp_out_of_range),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   task automatic send_word(logic op, int sel, longint temp, longint pres,
                            int row, int col, logic signed [VW-1:0] val);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_table_sel <= gtbi_pkg::SEL_W'(sel);
      req_temperature <= gtbi_pkg::TEMP_W'(temp);
      req_pressure <= gtbi_pkg::PRES_W'(pres);
      req_load_row <= gtbi_pkg::IDX_W'(row);
      req_load_col <= gtbi_pkg::IDX_W'(col);
      req_load_value <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_word(op, sel, temp, pres, row, col, val);
      sent_words++;
   endtask

   function automatic logic signed [VW-1:0] draw_value();
      case ($urandom_range(0, 7))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $urandom_range(0, 2000) - 1000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_load(int sel, int row, int col, logic signed [VW-1:0] val);
      send_word(gtbi_pkg::OP_LOAD, sel, $urandom_range(0, 131071), $urandom_range(0, 65535),
                row, col, val);
   endtask

   // Corners that were never loaded get a word first, so no lookup reads an empty entry.
   task automatic send_lookup(int sel, longint temp, longint pres);
      int it, jp;
      longint ft, fp;
      if (sb.find_cell(temp, sb.temp_origin, sb.temp_step, sb.temp_used, TPTS, it, ft) &&
          sb.find_cell(pres, sb.pres_origin, sb.pres_step, sb.pres_used, PPTS, jp, fp)) begin
         for (int dr = 0; dr < 2; dr++)
            for (int dc = 0; dc < 2; dc++)
               if (!sb.written[sb.addr_of(sel, it + dr, jp + dc)])
                  send_load(sel, it + dr, jp + dc, draw_value());
      end
      send_word(gtbi_pkg::OP_LOOKUP, sel, temp, pres, $urandom_range(0, 63),
                $urandom_range(0, 63), $urandom);
   endtask

   function automatic longint draw_pos(longint origin, longint step, longint used,
                                       longint limit, longint maxv);
      longint n, pos;
      int r;
      n = (used > limit) ? limit : used;
      r = $urandom_range(0, 9);
      if (r == 0 || n < 2 || step == 0) pos = $urandom_range(0, maxv);
      else if (r == 1) pos = origin - $urandom_range(1, 4);
      else if (r == 2) pos = origin + longint'($urandom_range(0, n - 1)) * step;
      else pos = origin + longint'($urandom) % ((n - 1) * step);
      if (pos < 0 || pos > maxv) pos = $urandom_range(0, maxv);
      return pos;
   endfunction

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CIW-1:0] idx, longint value, int width);
      logic [CDW-1:0] data;
      data = $urandom;
      data = (data << width) | CDW'(value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_reg(idx, data);
   endtask

   task automatic write_grid(longint c[6]);
      write_reg(gtbi_pkg::CSR_TEMP_ORIGIN, c[0], gtbi_pkg::TEMP_W);
      write_reg(gtbi_pkg::CSR_TEMP_STEP, c[1], gtbi_pkg::STEP_W);
      write_reg(gtbi_pkg::CSR_PRES_ORIGIN, c[2], gtbi_pkg::PRES_W);
      write_reg(gtbi_pkg::CSR_PRES_STEP, c[3], gtbi_pkg::STEP_W);
      write_reg(gtbi_pkg::CSR_TEMP_USED, c[4], gtbi_pkg::USED_W);
      write_reg(gtbi_pkg::CSR_PRES_USED, c[5], gtbi_pkg::USED_W);
      write_reg(CSR_SPARE_LO, $urandom, CDW);
      write_reg(CSR_SPARE_HI, $urandom, CDW);
      csr_valid <= 1'b0;
   endtask

   initial begin
      longint grids [PHASES][6];
      longint cur [6];
      longint tb0, pb0;
      int n;
      grids = '{'{71206, 256, 24800, 160, 64, 64},
                '{0, 1, 0, 1, 2, 2},
                '{131071, 65535, 65535, 65535, 64, 64},
                '{1000, 37, 500, 3, 9, 5},
                '{0, 65535, 0, 65535, 127, 127},
                '{5000, 0, 100, 20, 8, 8},
                '{100, 50, 100, 50, 1, 8},
                '{2000, 300, 3000, 7, 0, 64},
                '{0, 0, 0, 0, 0, 0},
                '{12345, 1000, 40000, 255, 33, 17}};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      tb0 = gtbi_pkg::TEMP_ORIGIN_RST;
      pb0 = gtbi_pkg::PRES_ORIGIN_RST;
      send_load(0, 0, 0, 32'sh7fffffff);
      send_load(0, 1, 0, 32'sh80000000);
      send_load(0, 0, 1, 100);
      send_load(0, 1, 1, -3);
      send_load(7, 63, 63, 32'sh80000000);
      send_lookup(0, tb0, pb0);
      send_lookup(0, tb0 + 128, pb0 + 80);
      send_lookup(0, tb0 + 255, pb0 + 159);
      send_lookup(0, tb0 + 1, pb0);
      send_lookup(0, tb0 + 63 * 256, pb0);
      send_lookup(0, tb0, pb0 + 63 * 160);
      send_lookup(0, tb0 - 1, pb0);
      send_lookup(0, tb0, pb0 - 1);
      send_lookup(7, 0, 0);
      send_lookup(7, 131071, 65535);
      send_lookup(7, tb0 + 62 * 256 + 255, pb0 + 62 * 160 + 159);
      send_lookup(7, tb0 + 62 * 256, pb0 + 62 * 160);

      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         cur = grids[ph];
         if (ph == 8) begin
            cur[0] = $urandom_range(0, 131071);
            cur[1] = $urandom_range(1, 65535);
            cur[2] = $urandom_range(0, 65535);
            cur[3] = $urandom_range(1, 65535);
            cur[4] = $urandom_range(2, 64);
            cur[5] = $urandom_range(2, 64);
         end
         write_grid(cur);
         req_idle_on = (ph % 3) != 1;
         rsp_idle_on = (ph % 4) != 2;
         n = 0;
         while (sent_words < (ph + 1) * ITEMS_PER_PHASE) begin
            if (ph == 3 && n == 20) hold_request = 1;
            if ($urandom_range(0, 6) == 0)
               send_load($urandom_range(0, TCNT - 1), $urandom_range(0, 63),
                         $urandom_range(0, 63), draw_value());
            else
               send_lookup($urandom_range(0, TCNT - 1),
                           draw_pos(sb.temp_origin, sb.temp_step, sb.temp_used, TPTS, 131071),
                           draw_pos(sb.pres_origin, sb.pres_step, sb.pres_used, PPTS, 65535));
            n++;
         end
      end

      drain();
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      int stall;
      forever begin
         if (hold_request) begin
            hold_request = 0;
            stall = HOLD_CYCLES;
         end else begin
            stall = rsp_idle_on ? $urandom_range(0, 16) : 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         sb.check_result(rsp_result_value, rsp_out_of_range);
      end
   end

   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// File: grid_table_bilinear_interp_unit.f
rtl/gtbi_pkg.sv
rtl/gtbi_ram.sv
rtl/gtbi_front.sv
rtl/gtbi_queue.sv
rtl/gtbi_div.sv
rtl/gtbi_back.sv
rtl/grid_table_bilinear_interp_unit.sv
rtl/gtbi_checker.sv
sim/grid_table_bilinear_interp_unit_tb.sv
